/* hw/rtl/lppc_pkg.sv */
// Package: shared types and constants for the line point parameter block.
package lppc_pkg;

  localparam int unsigned ATAN_DEPTH = 24;
  localparam int unsigned POS_W      = 18;
  localparam int unsigned STAT_W     = 2;

  localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;
  localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_LINE_KIND   = 3'd0,
    REG_REF_X       = 3'd1,
    REG_REF_Y       = 3'd2,
    REG_ARC_RADIUS  = 3'd3,
    REG_START_ANGLE = 3'd4,
    REG_LINE_LENGTH = 3'd5
  } reg_idx_t;

  // CORDIC rotation angles in 2^-32 turn
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] t;
    begin
      unique case (i)
        0:  t = 32'h20000000;  1:  t = 32'h12E4051E;  2:  t = 32'h09FB385B;
        3:  t = 32'h051111D4;  4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
        6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;  8:  t = 32'h0028BE53;
        9:  t = 32'h00145F2F;  10: t = 32'h000A2F98;  11: t = 32'h000517CC;
        12: t = 32'h00028BE6;  13: t = 32'h000145F3;  14: t = 32'h0000A2FA;
        15: t = 32'h0000517D;  16: t = 32'h000028BE;  17: t = 32'h0000145F;
        18: t = 32'h00000A30;  19: t = 32'h00000518;  20: t = 32'h0000028C;
        21: t = 32'h00000146;  22: t = 32'h000000A3;  23: t = 32'h00000051;
        default: t = 32'h0;
      endcase
      return t;
    end
  endfunction

endpackage

/* hw/rtl/lppc_cordic.sv */
// CORDIC vectoring pipeline: one register stage per iteration.
module lppc_cordic #(
  parameter int unsigned XW    = 34,
  parameter int unsigned STEPS = 16,
  parameter int unsigned SW    = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_vld,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  logic [31:0]          in_z,
  input  logic [SW-1:0]        in_side,
  output logic                 out_vld,
  output logic signed [XW-1:0] out_x,
  output logic [31:0]          out_z,
  output logic [SW-1:0]        out_side
);

  logic                 vld_r  [STEPS+1];
  logic signed [XW-1:0] x_r    [STEPS+1];
  logic signed [XW-1:0] y_r    [STEPS+1];
  logic [31:0]          z_r    [STEPS+1];
  logic [SW-1:0]        side_r [STEPS+1];

  always_comb begin
    vld_r[0]  = in_vld;
    x_r[0]    = in_x;
    y_r[0]    = in_y;
    z_r[0]    = in_z;
    side_r[0] = in_side;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_it
    logic signed [XW-1:0] xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    // Rotate towards the x axis
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[i+1] <= side_r[i];
        if (!y_r[i][XW-1]) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + ((i < lppc_pkg::ATAN_DEPTH) ? lppc_pkg::atan_turn(i) : 32'h0);
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - ((i < lppc_pkg::ATAN_DEPTH) ? lppc_pkg::atan_turn(i) : 32'h0);
        end
      end
    end
  end

  assign out_vld  = vld_r[STEPS];
  assign out_x    = x_r[STEPS];
  assign out_z    = z_r[STEPS];
  assign out_side = side_r[STEPS];

endmodule

/* hw/rtl/lppc_div.sv */
// Restoring divider pipeline: one quotient bit per stage, Q2.16 with saturation.
module lppc_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic          in_zero,
  output logic          out_vld,
  output logic [lppc_pkg::POS_W-1:0] out_pos,
  output logic [lppc_pkg::STAT_W-1:0] out_status
);

  // Quotient bits 17..0 of (num<<16)/den; saturation when num>=4*den
  localparam int unsigned QB = lppc_pkg::POS_W;
  localparam int unsigned RW = DW + 2;

  logic          vld_r  [QB+2];
  logic [NW+15:0] n_r   [QB+2];
  logic [RW-1:0] rem_r  [QB+2];
  logic [DW-1:0] den_r  [QB+2];
  logic [QB-1:0] q_r    [QB+2];
  logic          zero_r [QB+2];
  logic          sat_r  [QB+2];

  always_comb begin
    vld_r[0]  = in_vld;
    n_r[0]    = {in_num, 16'h0};
    rem_r[0]  = '0;
    den_r[0]  = in_den;
    q_r[0]    = '0;
    zero_r[0] = in_zero;
    sat_r[0]  = 1'b0;
  end

  // Saturation check: num / 4 >= den; seed the remainder with num / 4
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[1] <= 1'b0;
    end else if (adv) begin
      vld_r[1] <= vld_r[0];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      n_r[1]    <= n_r[0] << (NW + 16 - QB);
      rem_r[1]  <= RW'(in_num >> 2);
      den_r[1]  <= den_r[0];
      q_r[1]    <= '0;
      zero_r[1] <= zero_r[0];
      sat_r[1]  <= ((in_num >> 2) >= NW'(in_den));
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_q
    logic [RW:0] tr;
    assign tr = {rem_r[k], n_r[k][NW+15]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
    // Shift in one numerator bit, subtract when it fits
    always_ff @(posedge clk) begin
      if (adv) begin
        n_r[k+1]    <= n_r[k] << 1;
        den_r[k+1]  <= den_r[k];
        zero_r[k+1] <= zero_r[k];
        sat_r[k+1]  <= sat_r[k];
        if (tr >= (RW+1)'(den_r[k])) begin
          rem_r[k+1] <= RW'(tr - (RW+1)'(den_r[k]));
          q_r[k+1]   <= {q_r[k][QB-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= RW'(tr);
          q_r[k+1]   <= {q_r[k][QB-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld = vld_r[QB+1];
  always_comb begin
    if (zero_r[QB+1]) begin
      out_pos    = '0;
      out_status = lppc_pkg::ST_ZERO;
    end else if (sat_r[QB+1]) begin
      out_pos    = lppc_pkg::POS_MAX;
      out_status = lppc_pkg::ST_SAT;
    end else begin
      out_pos    = q_r[QB+1];
      out_status = lppc_pkg::ST_OK;
    end
  end

endmodule

/* hw/rtl/line_point_param_coord_top.sv */
// Top level: point to normalised line position, CORDIC then divider pipeline.
// Throughput: one transaction per cycle; every stage advances together and
// the whole pipeline holds while the output register is full and not taken.
// Reset (rst_n, synchronous, active low) clears valid bits and config registers to 0.
module line_point_param_coord_top #(
  parameter int unsigned COORD_WIDTH  = 32,
  parameter int unsigned ANGLE_WIDTH  = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lppc_pkg::POS_W-1:0]    out_position,
  output logic [lppc_pkg::STAT_W-1:0]   out_status
);

  localparam int unsigned XW = COORD_WIDTH + 3;
  localparam int unsigned MW = XW + 32;
  localparam int unsigned NW = COORD_WIDTH + 36;
  localparam int unsigned SW = 2;

  // Configuration registers
  logic                          line_kind_r;
  logic signed [COORD_WIDTH-1:0] ref_x_r, ref_y_r;
  logic [COORD_WIDTH-1:0]        arc_radius_r, line_length_r;
  logic [ANGLE_WIDTH-1:0]        start_angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_kind_r   <= 1'b0;
      ref_x_r       <= '0;
      ref_y_r       <= '0;
      arc_radius_r  <= '0;
      start_angle_r <= '0;
      line_length_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lppc_pkg::REG_LINE_KIND:   line_kind_r   <= cfg_data[0];
        lppc_pkg::REG_REF_X:       ref_x_r       <= cfg_data;
        lppc_pkg::REG_REF_Y:       ref_y_r       <= cfg_data;
        lppc_pkg::REG_ARC_RADIUS:  arc_radius_r  <= cfg_data;
        lppc_pkg::REG_START_ANGLE: start_angle_r <= cfg_data[ANGLE_WIDTH-1:0];
        lppc_pkg::REG_LINE_LENGTH: line_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: output register empty or taken
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: differences
  logic                 s1_vld_r;
  logic signed [XW-1:0] s1_dx_r, s1_dy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx_r <= XW'(in_point_x) - XW'(ref_x_r);
      s1_dy_r <= XW'(in_point_y) - XW'(ref_y_r);
    end
  end

  // Stage 2: fold into right half plane, flag origin
  logic                 s2_vld_r;
  logic signed [XW-1:0] s2_x_r, s2_y_r;
  logic [31:0]          s2_z_r;
  logic                 s2_org_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_org_r <= (s1_dx_r == '0) && (s1_dy_r == '0);
      if (s1_dx_r[XW-1]) begin
        s2_x_r <= -s1_dx_r;
        s2_y_r <= -s1_dy_r;
        s2_z_r <= 32'h80000000;
      end else begin
        s2_x_r <= s1_dx_r;
        s2_y_r <= s1_dy_r;
        s2_z_r <= 32'h0;
      end
    end
  end

  logic                 c_vld;
  logic signed [XW-1:0] c_x;
  logic [31:0]          c_z;
  logic [SW-1:0]        c_side;

  lppc_cordic #(.XW(XW), .STEPS(CORDIC_STEPS), .SW(SW)) u_cordic (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(s2_vld_r), .in_x(s2_x_r), .in_y(s2_y_r), .in_z(s2_z_r),
    .in_side({s2_org_r, 1'b0}),
    .out_vld(c_vld), .out_x(c_x), .out_z(c_z), .out_side(c_side)
  );

  // Stage 3: gain correction and angle to phi difference
  logic                   s3_vld_r;
  logic [MW-1:0]          s3_mag_r;
  logic [ANGLE_WIDTH-1:0] s3_diff_r;
  logic [ANGLE_WIDTH-1:0] theta, phi;
  logic [31:0]            zc;
  logic [XW-1:0]          ux;
  assign zc    = c_side[1] ? 32'h0 : c_z;
  assign theta = ANGLE_WIDTH'((zc + (32'h1 << (31 - ANGLE_WIDTH))) >> (32 - ANGLE_WIDTH));
  assign phi   = ANGLE_WIDTH'(3) << (ANGLE_WIDTH - 2);
  assign ux    = (c_side[1] || c_x[XW-1]) ? '0 : c_x;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= c_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_mag_r <= MW'(ux) * MW'(lppc_pkg::INV_GAIN_Q32);
      if (start_angle_r >= ANGLE_WIDTH'(phi - theta))
        s3_diff_r <= start_angle_r - ANGLE_WIDTH'(phi - theta);
      else
        s3_diff_r <= ANGLE_WIDTH'(phi - theta) - start_angle_r;
    end
  end

  // Stage 4: angle difference to radians Q3.29
  logic                s4_vld_r;
  logic [NW-1:0]       s4_mag_r;
  logic [ANGLE_WIDTH+31:0] s4_radp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_mag_r  <= NW'(s3_mag_r >> 32);
      s4_radp_r <= (ANGLE_WIDTH+32)'(s3_diff_r) * (ANGLE_WIDTH+32)'(lppc_pkg::TWO_PI_Q29);
    end
  end

  // Stage 5: arc length product
  logic                s5_vld_r;
  logic [NW-1:0]       s5_mag_r;
  logic [COORD_WIDTH+31:0] s5_arcp_r;
  logic [31:0]         rad;
  assign rad = 32'(s4_radp_r >> ANGLE_WIDTH);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s5_vld_r <= s4_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_mag_r  <= s4_mag_r;
      s5_arcp_r <= (COORD_WIDTH+32)'(arc_radius_r) * (COORD_WIDTH+32)'(rad);
    end
  end

  // Select length for the divider
  logic [NW-1:0] len;
  assign len = line_kind_r ? NW'(s5_arcp_r >> 29) : s5_mag_r;

  logic                         d_vld;
  logic [lppc_pkg::POS_W-1:0]   d_pos;
  logic [lppc_pkg::STAT_W-1:0]  d_status;

  lppc_div #(.NW(NW), .DW(COORD_WIDTH)) u_div (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(s5_vld_r), .in_num(len), .in_den(line_length_r),
    .in_zero(line_length_r == '0),
    .out_vld(d_vld), .out_pos(d_pos), .out_status(d_status)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_position <= d_pos;
      out_status   <= d_status;
    end
  end

  // Stall holds the result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position) && $stable(out_status))
    else $error("result changed while stalled");

  // Status code legal and consistent with position
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == lppc_pkg::ST_OK) || (out_status == lppc_pkg::ST_ZERO
      && out_position == '0) || (out_status == lppc_pkg::ST_SAT
      && out_position == lppc_pkg::POS_MAX))
    else $error("bad status");

  // Ready follows the output stage only
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule
